/* src/lbh_pkg.sv */
// ----------------------------------------------------------------------------
// Log-binned histogram package
// Shared constants, word types, job types and state codes of the histogram.
// ----------------------------------------------------------------------------
package lbh_pkg;

    localparam int GENES    = 1024;
    localparam int BINS     = 18;
    localparam int GENE_W   = 10;
    localparam int BIN_W    = 5;
    localparam int COUNT_W  = 32;
    localparam int SAMPLE_W = 64;
    localparam int EXP_W    = 11;
    localparam int MANT_W   = 52;
    localparam int EXP_BIAS = 1023;
    localparam int DEPTH    = GENES * BINS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [GENE_W-1:0]   gene;
        logic [SAMPLE_W-1:0] sample_bits;
        logic [BIN_W-1:0]    read_bin;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BIN_W-1:0]   bin;
        logic               skipped;
    } t_out_word;

    typedef enum logic [1:0] {
        JOB_UPDATE,
        JOB_READ,
        JOB_ECHO
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [BIN_W-1:0]  bin;
        logic              skipped;
    } t_job;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT
    } t_back_state;

endpackage

/* src/lbh_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lbh_front.sv */
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts input words, finds the bin of a sample from its exponent and
// mantissa bits, and turns each word into a job for the back end.
// ----------------------------------------------------------------------------
module lbh_front
    import lbh_pkg::*;
(
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    input  logic     i_full,
    input  logic     i_clearing,
    output logic     o_in_stall,
    output logic     o_push,
    output t_job     o_job
);

    localparam int K_W = EXP_W + 2;
    localparam logic signed [K_W-1:0] K_OFF = K_W'(EXP_BIAS - 2);
    localparam logic signed [K_W-1:0] K_MAX = K_W'(BINS - 1);

    logic                    w_sign;
    logic [EXP_W-1:0]        w_exp;
    logic                    w_mant_nz;
    logic signed [K_W-1:0]   w_k;
    logic [BIN_W-1:0]        w_bin;
    logic                    w_gene_ok;
    logic [BIN_W-1:0]        w_sel_bin;
    logic [ADDR_W-1:0]       w_addr;

    assign w_sign    = i_in_word.sample_bits[SAMPLE_W-1];
    assign w_exp     = i_in_word.sample_bits[MANT_W +: EXP_W];
    assign w_mant_nz = |i_in_word.sample_bits[MANT_W-1:0];
    assign w_k       = signed'({2'b00, w_exp}) + signed'({{(K_W-1){1'b0}}, w_mant_nz})
                       - K_OFF;

    always_comb begin
        if (w_sign || (w_exp == '0) || w_k[K_W-1]) begin
            w_bin = '0;
        end else if (w_k > K_MAX) begin
            w_bin = BIN_W'(BINS - 1);
        end else begin
            w_bin = w_k[BIN_W-1:0];
        end
    end

    assign w_gene_ok = 32'(i_in_word.gene) < 32'(GENES);
    assign w_sel_bin = (i_in_word.mode == MODE_READ) ? i_in_word.read_bin : w_bin;
    assign w_addr    = ADDR_W'(i_in_word.gene) * ADDR_W'(BINS) + ADDR_W'(w_sel_bin);

    always_comb begin
        o_job.addr    = w_addr;
        o_job.bin     = w_sel_bin;
        o_job.skipped = 1'b0;
        o_job.kind    = JOB_ECHO;
        if (i_in_word.mode == MODE_READ) begin
            if (w_gene_ok && (32'(i_in_word.read_bin) < 32'(BINS))) begin
                o_job.kind = JOB_READ;
            end
        end else if (w_exp == {EXP_W{1'b1}}) begin
            o_job.bin     = '0;
            o_job.skipped = 1'b1;
        end else if (w_gene_ok) begin
            o_job.kind = JOB_UPDATE;
        end
    end

    assign o_in_stall = i_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

/* src/lbh_queue.sv */
// ----------------------------------------------------------------------------
// Histogram job queue
// Short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module lbh_queue
    import lbh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

endmodule

/* src/lbh_back.sv */
// ----------------------------------------------------------------------------
// Histogram back end
// Clears the counter memory after reset, then carries out queued jobs, each a
// read-modify-write, a plain read or an echo, and drives the output register.
// ----------------------------------------------------------------------------
module lbh_back
    import lbh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_job      i_head,
    input  logic      i_out_stall,
    output logic      o_pop,
    output logic      o_clearing,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [ADDR_W-1:0]  n_clr;
    t_job               r_job;
    t_job               n_job;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_word          r_out;
    t_out_word          n_out;
    logic               w_out_free;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [COUNT_W-1:0] w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [COUNT_W-1:0] w_rdata;
    logic [COUNT_W-1:0] w_count;

    lbh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_count    = (r_job.kind == JOB_UPDATE) ? w_rdata + 1'b1 : w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_job       = r_job;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_clr;
        w_wdata     = '0;
        w_raddr     = i_head.addr;
        case (r_state)
            ST_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    if (i_head.kind == JOB_ECHO) begin
                        n_out_valid   = 1'b1;
                        n_out.count   = '0;
                        n_out.bin     = i_head.bin;
                        n_out.skipped = i_head.skipped;
                    end else begin
                        n_job   = i_head;
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                w_raddr = r_job.addr;
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.count   = w_count;
                    n_out.bin     = r_job.bin;
                    n_out.skipped = 1'b0;
                    w_we          = (r_job.kind == JOB_UPDATE);
                    w_waddr       = r_job.addr;
                    w_wdata       = w_count;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_no_word_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("Output word valid during the clearing pass.");

    a_write_only_clear_or_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == ST_CLEAR) || ((r_state == ST_WAIT) && (r_job.kind == JOB_UPDATE))))
        else $error("Counter memory written outside clearing or an update.");

    a_pop_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> ((r_state == ST_IDLE) && !i_empty))
        else $error("Job taken from the queue outside the idle state.");

    a_wait_ends_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WAIT) && (n_state == ST_IDLE)) |=> r_out_valid)
        else $error("Counter access finished without an output word.");

endmodule

/* src/log_binned_histogram_top.sv */
// ----------------------------------------------------------------------------
// Log-binned histogram top level
// After reset the block clears its 18432-entry counter memory, one entry per
// cycle, and stalls its input during that pass. Then a word whose sample
// is not finite, or whose gene or read bin is out of range, is answered from
// the idle state of the back end; a counter read or increment also needs the
// wait state for the registered memory read and an increment's write-back.
// A four-entry queue lets the input side keep accepting words meanwhile, and
// the output register lets the next word proceed as soon as a result is taken.
// ----------------------------------------------------------------------------
module log_binned_histogram_top
    import lbh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic w_push;
    t_job w_job;
    logic w_full;
    logic w_empty;
    t_job w_head;
    logic w_pop;
    logic w_clearing;

    lbh_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_full     (w_full),
        .i_clearing (w_clearing),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    lbh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    lbh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
